@@ design/tlt_pkg.sv @@
`timescale 1ns / 1ps
package tlt_pkg;

	localparam int AXES  = 3;
	localparam int PW    = 24;               // position width
	localparam int TW    = 32;               // time width
	localparam int QW    = 24;               // quotient bits produced by the divider
	localparam int NW    = 64;               // numerator and denominator factor width
	localparam int AW    = 90;               // dividend width, holds |d|*N + 4*D
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;

	localparam logic [TW-1:0] DURATION_RST = 32'd1000000;

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [IDX_W-1:0] {
		REG_START_X  = 3'd0,
		REG_START_Y  = 3'd1,
		REG_START_Z  = 3'd2,
		REG_GOAL_X   = 3'd3,
		REG_GOAL_Y   = 3'd4,
		REG_GOAL_Z   = 3'd5,
		REG_DURATION = 3'd6
	} reg_idx_t;

	// Per-axis data carried along the pipe.
	typedef struct packed {
		logic [PW-1:0] mag;    // |goal - start|
		logic [PW-1:0] base;   // point the scaled distance is applied to
		logic          sub;    // subtract the scaled distance from base
	} ax_t;

	// One item inside the divider.
	typedef struct packed {
		logic [AXES-1:0][AW-1:0] acc;
		logic [AXES-1:0][QW-1:0] quo;
		ax_t  [AXES-1:0]         ax;
		logic [NW-1:0]           den;
		phase_t                  ph;
	} div_t;

endpackage

@@ design/trapezoid_line_trajectory_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// config    in         cfg_we              cfg_index, cfg_wdata
// sample    in         in_valid/in_stall   elapsed_time
// position  out        out_valid/out_stall pos_x, pos_y, pos_z, phase
//
// One item enters per cycle while no result is held stalled at the output.
// The pipe holds a 24-stage restoring divider, one quotient bit per stage.
// arst_n clears all valid bits and loads the configuration registers with their reset values.
// A stalled result holds the whole pipe in place; in_stall is high exactly then.
module trapezoid_line_trajectory_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tlt_pkg::IDX_W-1:0]       cfg_index,
	input  logic [tlt_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tlt_pkg::TW-1:0]          elapsed_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [tlt_pkg::PW-1:0]   pos_x,
	output logic signed [tlt_pkg::PW-1:0]   pos_y,
	output logic signed [tlt_pkg::PW-1:0]   pos_z,
	output logic [1:0]                      phase
);
	import tlt_pkg::*;

	// Configuration registers.
	logic [AXES-1:0][PW-1:0] start_q, goal_q;
	logic [TW-1:0]           dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			goal_q  <= '0;
			dur_q   <= DURATION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X:  start_q[0] <= cfg_wdata[PW-1:0];
				REG_START_Y:  start_q[1] <= cfg_wdata[PW-1:0];
				REG_START_Z:  start_q[2] <= cfg_wdata[PW-1:0];
				REG_GOAL_X:   goal_q[0]  <= cfg_wdata[PW-1:0];
				REG_GOAL_Y:   goal_q[1]  <= cfg_wdata[PW-1:0];
				REG_GOAL_Z:   goal_q[2]  <= cfg_wdata[PW-1:0];
				REG_DURATION: dur_q      <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipe moves together unless the output holds an untaken result.
	logic out_valid_q;
	logic en;
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Stage 1: classify the time and set up each axis.
	logic [TW+2:0] t5;
	logic [TW+3:0] t10m;
	phase_t        ph_c;
	logic [TW-1:0] u_c;
	ax_t [AXES-1:0] ax_c;

	assign t5   = {1'b0, elapsed_time, 2'b00} + {3'b000, elapsed_time};
	assign t10m = {t5, 1'b0} - {4'b0000, dur_q};

	always_comb begin
		if (dur_q == '0 || elapsed_time >= dur_q) begin
			ph_c = PH_DONE;
		end else if (t5 <= {3'b000, dur_q}) begin
			ph_c = PH_ACCEL;
		end else if (t5 <= {1'b0, dur_q, 2'b00}) begin
			ph_c = PH_CRUISE;
		end else begin
			ph_c = PH_DECEL;
		end
	end

	logic [TW+2:0] v5;
	assign v5  = {1'b0, dur_q - elapsed_time, 2'b00} + {3'b000, dur_q - elapsed_time};
	assign u_c = (ph_c == PH_DECEL) ? v5[TW-1:0] : t5[TW-1:0];

	always_comb begin
		logic signed [PW:0] d;
		logic [PW:0]        ad;
		for (int a = 0; a < AXES; a++) begin
			d  = {goal_q[a][PW-1], goal_q[a]} - {start_q[a][PW-1], start_q[a]};
			ad = d[PW] ? -d : d;
			ax_c[a].mag  = ad[PW-1:0];
			ax_c[a].base = (ph_c == PH_DECEL || ph_c == PH_DONE) ? goal_q[a] : start_q[a];
			ax_c[a].sub  = d[PW] ^ (ph_c == PH_DECEL);
		end
	end

	logic            vld_s1;
	phase_t          ph_s1;
	logic [TW-1:0]   u_s1, dur_s1;
	logic [TW+2:0]   nc_s1;
	ax_t [AXES-1:0]  ax_s1;

	// Stage 2: squares for the ramps, linear terms for cruise.
	logic            vld_s2;
	phase_t          ph_s2;
	logic [NW-1:0]   num_s2, den_s2;
	ax_t [AXES-1:0]  ax_s2;

	// Stage 3: low half of |d| * N.
	logic                         vld_s3;
	phase_t                       ph_s3;
	logic [NW-1:0]                num_s3, den_s3;
	ax_t [AXES-1:0]               ax_s3;
	logic [AXES-1:0][PW+TW-1:0]   pl_s3;

	// Stage 4 onward: dividend is |d|*N + 4*D, divisor 8*D, giving round(|d|*N/(8*D)).
	logic [QW:0] dvld_s;
	div_t        div_s [QW+1];
	div_t        div4_c;

	always_comb begin
		logic [PW+TW-1:0] ph_hi;
		div4_c.den = den_s3;
		div4_c.ph  = ph_s3;
		div4_c.ax  = ax_s3;
		div4_c.quo = '0;
		for (int a = 0; a < AXES; a++) begin
			ph_hi = (PW+TW)'(ax_s3[a].mag) * (PW+TW)'(num_s3[NW-1:TW]);
			div4_c.acc[a] = AW'(pl_s3[a]) + (AW'(ph_hi) << TW) + AW'({den_s3, 2'b00});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			dvld_s <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			dvld_s <= {dvld_s[QW-1:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= ph_c;
			u_s1   <= u_c;
			dur_s1 <= dur_q;
			nc_s1  <= t10m[TW+2:0];
			ax_s1  <= ax_c;

			ph_s2  <= ph_s1;
			ax_s2  <= ax_s1;
			num_s2 <= (ph_s1 == PH_CRUISE) ? NW'(nc_s1) : NW'(u_s1) * NW'(u_s1);
			den_s2 <= (ph_s1 == PH_CRUISE) ? NW'(dur_s1) : NW'(dur_s1) * NW'(dur_s1);

			ph_s3  <= ph_s2;
			ax_s3  <= ax_s2;
			num_s3 <= num_s2;
			den_s3 <= den_s2;
			for (int a = 0; a < AXES; a++) begin
				pl_s3[a] <= (PW+TW)'(ax_s2[a].mag) * (PW+TW)'(num_s2[TW-1:0]);
			end

			div_s[0] <= div4_c;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		div_t nx_c;
		always_comb begin
			logic [AW-1:0] dd;
			nx_c = div_s[j];
			dd   = AW'({div_s[j].den, 3'b000}) << B;
			for (int a = 0; a < AXES; a++) begin
				if (div_s[j].acc[a] >= dd) begin
					nx_c.acc[a]    = div_s[j].acc[a] - dd;
					nx_c.quo[a][B] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j+1] <= nx_c;
			end
		end
	end

	// Output register: apply the signed offset to the base point.
	logic [AXES-1:0][PW-1:0] pos_q;
	phase_t                  phase_q;
	logic [AXES-1:0][PW-1:0] pos_c;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (div_s[QW].ph == PH_DONE) begin
				pos_c[a] = div_s[QW].ax[a].base;
			end else if (div_s[QW].ax[a].sub) begin
				pos_c[a] = div_s[QW].ax[a].base - div_s[QW].quo[a];
			end else begin
				pos_c[a] = div_s[QW].ax[a].base + div_s[QW].quo[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dvld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q   <= pos_c;
			phase_q <= div_s[QW].ph;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_q[0];
	assign pos_y     = pos_q[1];
	assign pos_z     = pos_q[2];
	assign phase     = phase_q;

	// A finished move always reports the goal point.
	a_done_goal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && phase_q == PH_DONE |-> pos_q == goal_q)
		else $error("finished result is not the goal");

	// Input is held back only by a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled without a held result");

	// The X-axis divider remainder ends below the divisor on every valid sample that is not done.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s[QW] && div_s[QW].ph != PH_DONE |->
		div_s[QW].acc[0] < AW'({div_s[QW].den, 3'b000}))
		else $error("divider remainder out of range");

	// Results advance one stage per enabled cycle.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && dvld_s[QW] |=> out_valid_q)
		else $error("result lost at the output register");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import tlt_pkg::*;

	// Register index that maps to no register; a write to it must be ignored.
	localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;
	localparam int PIPE_LAT = 28;

	typedef struct packed {
		logic [AXES-1:0][PW-1:0] pos;
		phase_t                  ph;
	} point_t;

	typedef struct {
		bit                 is_write;
		bit                 typed;
		logic [IDX_W-1:0]   idx;
		logic [CFG_W-1:0]   val;
		point_t             want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [TW-1:0]        elapsed_time;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [PW-1:0] pos_x;
	logic signed [PW-1:0] pos_y;
	logic signed [PW-1:0] pos_z;
	logic [1:0]           phase;

	// Shadow copy of the configuration, updated at every register write.
	logic signed [PW-1:0] start_pt [AXES];
	logic signed [PW-1:0] goal_pt  [AXES];
	logic [TW-1:0]        dur_ref;

	point_t pending_pos [$];
	row_t   directed [$];
	int     errors;
	int     hold_left;
	bit     send_burst;
	bit     recv_burst;

	trapezoid_line_trajectory_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .elapsed_time(elapsed_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .phase(phase)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Expected position for elapsed time t under the shadow configuration.
	// Each fraction d*num/den is taken on |d| and rounded half away from zero.
	function automatic point_t line_point(logic [TW-1:0] t);
		point_t        r;
		logic [63:0]   u;
		logic [127:0]  num;
		logic [127:0]  den;
		logic [127:0]  q;
		longint        d;
		longint        mag;
		longint        base;
		bit            from_goal;
		if (dur_ref == 0 || t >= dur_ref) begin
			r.ph = PH_DONE;
			for (int a = 0; a < AXES; a++)
				r.pos[a] = goal_pt[a];
			return r;
		end
		if (64'(t) * 5 <= 64'(dur_ref)) begin
			u = 64'(t) * 5;
			num = 128'(u) * 128'(u);
			den = (128'(dur_ref) * 128'(dur_ref)) << 3;
			from_goal = 1'b0;
			r.ph = PH_ACCEL;
		end else if (64'(t) * 5 <= 64'(dur_ref) * 4) begin
			num = 128'(64'(t) * 10 - 64'(dur_ref));
			den = 128'(dur_ref) << 3;
			from_goal = 1'b0;
			r.ph = PH_CRUISE;
		end else begin
			u = 64'(dur_ref - t) * 5;
			num = 128'(u) * 128'(u);
			den = (128'(dur_ref) * 128'(dur_ref)) << 3;
			from_goal = 1'b1;
			r.ph = PH_DECEL;
		end
		for (int a = 0; a < AXES; a++) begin
			d = longint'(goal_pt[a]) - longint'(start_pt[a]);
			mag = (d < 0) ? -d : d;
			q = (128'(mag) * num * 2 + den) / (den * 2);
			if (d < 0)
				q = -q;
			base = from_goal ? longint'(goal_pt[a]) : longint'(start_pt[a]);
			r.pos[a] = from_goal ? PW'(base - longint'(q)) : PW'(base + longint'(q));
		end
		return r;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_GOAL_X)
			start_pt[idx] = data[PW-1:0];
		else if (idx < REG_DURATION)
			goal_pt[idx - REG_GOAL_X] = data[PW-1:0];
		else if (idx == REG_DURATION)
			dur_ref = data;
	endtask

	// Drop valid and wait until every outstanding result has been seen.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Present one sample and hold it until the transfer happens. Valid is
	// lowered only when a gap follows, so back-to-back items keep it high.
	task automatic send_time(logic [TW-1:0] t, bit typed, point_t want);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		elapsed_time <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_pos.insert(pending_pos.size(), typed ? want : line_point(t));
	endtask

	function automatic logic [PW-1:0] pick_pos();
		case ($urandom_range(0, 7))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			default: return PW'($urandom);
		endcase
	endfunction

	function automatic logic [TW-1:0] pick_duration();
		case ($urandom_range(0, 11))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return 32'd1;
			3, 4, 5: return $urandom_range(2, 100);
			6, 7: return $urandom_range(100, 100000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [TW-1:0] pick_time();
		int k;
		k = $urandom_range(0, 9);
		if (dur_ref == 0 || k == 0)
			return $urandom;
		if (k == 1)
			return dur_ref - $urandom_range(0, 1);
		if (k == 2)
			return dur_ref / 5 + $urandom_range(0, 1);
		if (k == 3)
			return 32'((64'(dur_ref) * 4) / 5) + $urandom_range(0, 1);
		return $urandom_range(0, dur_ref);
	endfunction

	function automatic point_t pt(logic [PW-1:0] x, logic [PW-1:0] y, logic [PW-1:0] z,
			phase_t ph);
		point_t r;
		r.pos[0] = x;
		r.pos[1] = y;
		r.pos[2] = z;
		r.ph = ph;
		return r;
	endfunction

	function automatic void add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		row_t r;
		r.is_write = 1'b1;
		r.typed = 1'b0;
		r.idx = idx;
		r.val = data;
		r.want = '0;
		directed.insert(directed.size(), r);
	endfunction

	function automatic void add_time(logic [TW-1:0] t);
		row_t r;
		r.is_write = 1'b0;
		r.typed = 1'b0;
		r.idx = '0;
		r.val = t;
		r.want = '0;
		directed.insert(directed.size(), r);
	endfunction

	function automatic void add_known(logic [TW-1:0] t, point_t want);
		row_t r;
		r.is_write = 1'b0;
		r.typed = 1'b1;
		r.idx = '0;
		r.val = t;
		r.want = want;
		directed.insert(directed.size(), r);
	endfunction

	// Result checker and stall generator. A result transfer takes place at an
	// edge where out_valid is high and out_stall is low; after each one the
	// receiver draws how long it stalls before taking the next.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				$display("%0t: result with nothing expected: x=%0d y=%0d z=%0d phase=%0d",
					$time, pos_x, pos_y, pos_z, phase);
				errors++;
			end else begin
				point_t e;
				e = pending_pos.pop_front();
				if (pos_x !== e.pos[0]) begin
					$display("%0t: pos_x expected %0d actual %0d", $time,
						$signed(e.pos[0]), pos_x);
					errors++;
				end
				if (pos_y !== e.pos[1]) begin
					$display("%0t: pos_y expected %0d actual %0d", $time,
						$signed(e.pos[1]), pos_y);
					errors++;
				end
				if (pos_z !== e.pos[2]) begin
					$display("%0t: pos_z expected %0d actual %0d", $time,
						$signed(e.pos[2]), pos_z);
					errors++;
				end
				if (phase !== e.ph) begin
					$display("%0t: phase expected %0d actual %0d", $time, e.ph, phase);
					errors++;
				end
			end
			hold_left = recv_burst ? 0 : $urandom_range(0, 11);
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0);
	end

	// Stimulus: directed table first, then random phases, each with its own
	// configuration written while the pipe is empty.
	initial begin
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		elapsed_time = '0;
		out_stall    = 1'b0;
		errors       = 0;
		hold_left    = 0;
		send_burst   = 1'b0;
		recv_burst   = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			start_pt[a] = '0;
			goal_pt[a]  = '0;
		end
		dur_ref = DURATION_RST;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: all points at the origin over a move of duration 1000000.
		add_known(32'd0, pt(24'd0, 24'd0, 24'd0, PH_ACCEL));
		add_known(32'd1000000, pt(24'd0, 24'd0, 24'd0, PH_DONE));
		add_time(32'd500000);
		// Full-span moves in opposite directions, one axis standing still.
		add_write(REG_START_X, 32'hFF800000);
		add_write(REG_GOAL_X, 32'h007FFFFF);
		add_write(REG_START_Y, 32'h007FFFFF);
		add_write(REG_GOAL_Y, 32'hAB800000);
		add_write(REG_START_Z, 32'd5);
		add_write(REG_GOAL_Z, 32'd5);
		add_write(REG_DURATION, 32'd1000);
		add_known(32'd0, pt(24'h800000, 24'h7FFFFF, 24'd5, PH_ACCEL));
		add_time(32'd200);
		add_time(32'd201);
		add_time(32'd800);
		add_time(32'd801);
		add_time(32'd999);
		add_known(32'd1000, pt(24'h7FFFFF, 24'h800000, 24'd5, PH_DONE));
		add_known(32'hFFFFFFFF, pt(24'h7FFFFF, 24'h800000, 24'd5, PH_DONE));
		// Longest move: products reach their widest here.
		add_write(REG_DURATION, 32'hFFFFFFFF);
		add_time(32'h33333333);
		add_time(32'hCCCCCCCC);
		add_time(32'hFFFFFFFE);
		add_known(32'hFFFFFFFF, pt(24'h7FFFFF, 24'h800000, 24'd5, PH_DONE));
		// Zero duration always sits at the goal.
		add_write(REG_DURATION, 32'd0);
		add_known(32'd0, pt(24'h7FFFFF, 24'h800000, 24'd5, PH_DONE));
		// A write to an unused index changes nothing.
		add_write(IDX_UNUSED, 32'd12345);
		add_write(REG_DURATION, 32'd1);
		add_known(32'd0, pt(24'h800000, 24'h7FFFFF, 24'd5, PH_ACCEL));
		add_known(32'd1, pt(24'h7FFFFF, 24'h800000, 24'd5, PH_DONE));

		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				drain();
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				send_time(directed[i].val, directed[i].typed, directed[i].want);
			end
		end

		for (int ph = 0; ph < 10; ph++) begin
			drain();
			send_burst = (ph % 3 == 1);
			recv_burst = (ph % 4 == 2);
			for (int a = 0; a < AXES; a++) begin
				write_reg(IDX_W'(REG_START_X + a), {8'($urandom), pick_pos()});
				write_reg(IDX_W'(REG_GOAL_X + a), {8'($urandom), pick_pos()});
			end
			write_reg(REG_DURATION, (ph == 0) ? 32'hFFFFFFFF : pick_duration());
			if ($urandom_range(0, 3) == 0)
				write_reg(IDX_UNUSED, $urandom);
			for (int n = 0; n < 170; n++)
				send_time(pick_time(), 1'b0, '0);
		end

		drain();
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0 && pending_pos.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/tlt_pkg.sv
design/trapezoid_line_trajectory_top.sv
sim/tb.sv
